@@ src/pce_pkg.sv @@
package pce_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int NUM_SYMBOLS      = 769;
    localparam int SYM_W            = 10;
    localparam int SYM_NEWLINE      = 767;
    localparam int SYM_END          = 768;
    localparam int ACTUAL_BASE      = 511;
    localparam int DIFF_BASE        = 255;
    localparam int IN_LEN_W         = 6;
    localparam int IN_CODE_W        = 32;
    localparam int VALUE_W          = 9;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_DIFF    = 2'd0,
        KIND_ACTUAL  = 2'd1,
        KIND_NEWLINE = 2'd2
    } t_kind;

    // control bits of the looked-up item handed from the table stage to the bit packer
    typedef struct packed {
        logic valid;
        logic finish;
    } t_lk_ctl;

endpackage

@@ src/pce_ram.sv @@
module pce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pce_lookup.sv @@
module pce_lookup #(
    parameter int MAX_CODE_LEN = pce_pkg::MAX_CODE_LEN_DEF,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [pce_pkg::SYM_W-1:0]     i_table_index,
    input  logic [pce_pkg::IN_CODE_W-1:0] i_entry_code,
    input  logic [pce_pkg::IN_LEN_W-1:0]  i_entry_length,
    input  logic [1:0]                    i_symbol_kind,
    input  logic [pce_pkg::VALUE_W-1:0]   i_symbol_value,
    output pce_pkg::t_lk_ctl              o_ctl,
    output logic [MAX_CODE_LEN-1:0]       o_code,
    output logic [LEN_W-1:0]              o_len,
    input  logic                          i_take
);

    import pce_pkg::*;

    localparam int DW = MAX_CODE_LEN + LEN_W;

    logic             r_clearing;
    logic [SYM_W-1:0] r_clr_addr;
    t_lk_ctl          r_ctl;

    logic                    accept;
    logic                    v_load;
    logic                    v_finish;
    logic                    v_wr;
    logic [SYM_W-1:0]        v_sym;
    logic [SYM_W-1:0]        v_diff_sum;
    logic [LEN_W-1:0]        v_len;
    logic [MAX_CODE_LEN-1:0] v_code;
    logic                    ram_we;
    logic [SYM_W-1:0]        ram_waddr;
    logic [DW-1:0]           ram_wdata;
    logic [DW-1:0]           ram_rdata;

    assign o_ready = !r_clearing && (!r_ctl.valid || i_take);
    assign accept  = i_valid && o_ready;

    // symbol mapping, write-entry shaping
    always_comb begin
        v_load     = 1'b0;
        v_finish   = 1'b0;
        v_wr       = 1'b0;
        v_sym      = SYM_W'(SYM_END);
        v_diff_sum = {i_symbol_value[VALUE_W-1], i_symbol_value} + SYM_W'(DIFF_BASE);
        case (t_action'(i_action))
            ACT_WRITE: begin
                v_wr = (i_table_index <= SYM_W'(SYM_END));
            end
            ACT_ENCODE: begin
                case (t_kind'(i_symbol_kind))
                    KIND_DIFF: begin
                        v_load = 1'b1;
                        // -256 saturates to symbol 0
                        v_sym  = (i_symbol_value == {1'b1, {(VALUE_W-1){1'b0}}}) ?
                                 '0 : v_diff_sum;
                    end
                    KIND_ACTUAL: begin
                        v_load = 1'b1;
                        v_sym  = i_symbol_value[VALUE_W-1] ? SYM_W'(ACTUAL_BASE) :
                                 SYM_W'(i_symbol_value[VALUE_W-2:0]) + SYM_W'(ACTUAL_BASE);
                    end
                    KIND_NEWLINE: begin
                        v_load = 1'b1;
                        v_sym  = SYM_W'(SYM_NEWLINE);
                    end
                    default: begin
                        v_load = 1'b0;
                    end
                endcase
            end
            ACT_FINISH: begin
                v_load   = 1'b1;
                v_finish = 1'b1;
            end
            default: begin
                v_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        v_len  = (i_entry_length > IN_LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) :
                 LEN_W'(i_entry_length);
        v_code = MAX_CODE_LEN'(i_entry_code) & ~({MAX_CODE_LEN{1'b1}} << v_len);
    end

    // clearing pass owns the write port until it is done
    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = accept && v_wr;
            ram_waddr = i_table_index;
            ram_wdata = {v_len, v_code};
        end
    end

    pce_ram #(
        .WIDTH(DW),
        .DEPTH(NUM_SYMBOLS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (accept && v_load),
        .i_raddr(v_sym),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_ctl      <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == SYM_W'(SYM_END)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_ctl.valid  <= v_load;
                r_ctl.finish <= v_finish;
            end else if (i_take) begin
                r_ctl.valid <= 1'b0;
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_code = ram_rdata[MAX_CODE_LEN-1:0];
    assign o_len  = ram_rdata[DW-1:MAX_CODE_LEN];

endmodule

@@ src/pce_packer.sv @@
module pce_packer #(
    parameter int MAX_CODE_LEN = pce_pkg::MAX_CODE_LEN_DEF,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pce_pkg::t_lk_ctl        i_ctl,
    input  logic [MAX_CODE_LEN-1:0] i_code,
    input  logic [LEN_W-1:0]        i_len,
    output logic                    o_take,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_byte,
    output logic                    o_last,
    output logic                    o_end
);

    import pce_pkg::*;

    localparam int ACC_W = MAX_CODE_LEN + 7;
    localparam int CNT_W = $clog2(MAX_CODE_LEN + 8);

    // bits above r_cnt in r_acc are stale and never read
    logic [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_fin;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast;
    logic             r_oend;

    logic             out_free;
    logic             has_full;
    logic             emit_full;
    logic             emit_pad;
    logic [CNT_W-1:0] rem;
    logic [CNT_W-1:0] base_cnt;
    logic [ACC_W-1:0] v_shifted;
    logic [2:0]       v_pad;
    logic [7:0]       v_byte;
    logic             v_last;
    logic             v_end;
    logic [ACC_W-1:0] n_acc;
    logic [CNT_W-1:0] n_cnt;
    logic             n_fin;

    assign out_free  = !r_ovalid || i_ready;
    assign has_full  = (r_cnt >> 3) != '0;
    assign emit_full = has_full && out_free;
    assign emit_pad  = r_fin && !has_full && (r_cnt != '0) && out_free;
    assign rem       = r_cnt - CNT_W'(8);
    assign base_cnt  = emit_full ? rem : r_cnt;
    // a new code may join in the cycle that sends the last full byte
    assign o_take    = i_ctl.valid && !r_fin &&
                       (!has_full || (((r_cnt >> 3) < CNT_W'(2)) && emit_full));

    always_comb begin
        v_shifted = r_acc >> rem;
        v_pad     = 3'(4'd8 - {1'b0, r_cnt[2:0]});
        if (has_full) begin
            v_byte = v_shifted[7:0];
            v_last = r_fin ? (rem == '0) : ((rem >> 3) == '0);
            v_end  = r_fin && (rem == '0);
        end else begin
            v_byte = (r_acc[7:0] << v_pad) | (8'hFF >> r_cnt[2:0]);
            v_last = 1'b1;
            v_end  = 1'b1;
        end
    end

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_fin = r_fin;
        if (o_take) begin
            n_acc = (r_acc << i_len) | ACC_W'(i_code);
            n_cnt = base_cnt + CNT_W'(i_len);
            n_fin = i_ctl.finish;
        end else if (emit_full) begin
            n_cnt = rem;
            if (r_fin && rem == '0) begin
                n_fin = 1'b0;
            end
        end else if (emit_pad) begin
            n_cnt = '0;
            n_fin = 1'b0;
        end else if (r_fin && r_cnt == '0) begin
            n_fin = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (emit_full || emit_pad) begin
            r_obyte <= v_byte;
            r_olast <= v_last;
            r_oend  <= v_end;
        end
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_fin <= n_fin;
            if (emit_full || emit_pad) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_end   = r_oend;

endmodule

@@ src/prefix_code_stream_encoder.sv @@
// Channel     | Direction | tdata (low bit up)                         | tuser / tlast
// ------------+-----------+--------------------------------------------+-------------------------
// s_axis      | in        | table_index, entry_code, entry_length,     | tuser: action,
//             |           | symbol_value, zero fill to 64 bits         |        symbol_kind
// m_axis      | out       | out_byte                                   | tlast: last_of_run
//             |           |                                            | tuser: stream_end
//
// Flow: an item enters every cycle while the packer has fewer than 8 bits pending
//   and no finish is draining; an encode yielding k bytes (at most 4 for a 32-bit
//   code, MAX_CODE_LEN/8 rounded up in general) holds off the next code until its
//   last byte leaves, one byte a cycle while m_axis is ready; a finish pads with ones.
// Reset: after reset a clearing pass writes all 769 table entries, one per cycle;
//   s_axis_tready stays low until the pass is done.
// Stalls: a stalled m_axis holds the output byte; the table stage keeps its read
//   data until the packer takes it, and s_axis_tready stays low meanwhile.
module prefix_code_stream_encoder #(
    parameter int MAX_CODE_LEN = pce_pkg::MAX_CODE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [9:0] table_index, [41:10] entry_code, [47:42] entry_length,
    // [56:48] symbol_value, [63:57] zero
    input  logic [63:0] i_s_axis_tdata,
    // [1:0] action, [3:2] symbol_kind
    input  logic [3:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // [0] stream_end
    output logic [0:0]  o_m_axis_tuser
);

    import pce_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    t_lk_ctl                 lk_ctl;
    logic [MAX_CODE_LEN-1:0] lk_code;
    logic [LEN_W-1:0]        lk_len;
    logic                    lk_take;

    // table stage: clearing pass, symbol mapping, entry writes and lookups
    pce_lookup #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .LEN_W       (LEN_W)
    ) u_lookup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_action      (i_s_axis_tuser[1:0]),
        .i_table_index (i_s_axis_tdata[9:0]),
        .i_entry_code  (i_s_axis_tdata[41:10]),
        .i_entry_length(i_s_axis_tdata[47:42]),
        .i_symbol_kind (i_s_axis_tuser[3:2]),
        .i_symbol_value(i_s_axis_tdata[56:48]),
        .o_ctl         (lk_ctl),
        .o_code        (lk_code),
        .o_len         (lk_len),
        .i_take        (lk_take)
    );

    // bit packer: appends codes MSB first, sends bytes, pads on finish
    pce_packer #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .LEN_W       (LEN_W)
    ) u_packer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (lk_ctl),
        .i_code (lk_code),
        .i_len  (lk_len),
        .o_take (lk_take),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_byte (o_m_axis_tdata),
        .o_last (o_m_axis_tlast),
        .o_end  (o_m_axis_tuser[0])
    );

endmodule

@@ dv/tb_prefix_code_stream_encoder.sv @@
`timescale 1ns / 1ps

module tb_prefix_code_stream_encoder;
    import pce_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int MAX_LEN     = MAX_CODE_LEN_DEF;
    localparam int STALL_LIMIT = 4000;   // covers the table clear after reset
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eos;
    } t_out_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [9:0] table_index, [41:10] entry_code, [47:42] entry_length,
    // [56:48] symbol_value, [63:57] zero
    logic [63:0] i_s_axis_tdata = '0;
    // [1:0] action, [3:2] symbol_kind
    logic [3:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [7:0] out_byte
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;
    // [0] stream_end
    logic [0:0]  o_m_axis_tuser;

    prefix_code_stream_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: code table and the pending bit accumulator
    // ------------------------------------------------------------------
    logic [31:0] code_tbl [0:NUM_SYMBOLS-1];
    int          len_tbl  [0:NUM_SYMBOLS-1];
    logic [63:0] acc_bits;
    int          acc_cnt;

    t_out_byte   packed_bytes_q [$];   // bytes still owed by the block
    t_out_byte   head_byte;
    int          fail_count = 0;
    int          idle_cycles = 0;

    bit          tx_idle_en = 1'b0;
    bit          rx_stall_en = 1'b0;
    int          rx_hold = 0;

    int          hot_syms [0:15];      // symbols the random traffic mostly uses

    function automatic logic [63:0] low_ones(int n);
        return (64'd1 << n) - 64'd1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic append_sym(int sym);
        int l;
        l = len_tbl[sym];
        acc_bits = (acc_bits << l) | {32'd0, code_tbl[sym]};
        acc_cnt  = acc_cnt + l;
    endtask

    task automatic drain_full(ref t_out_byte run [$]);
        t_out_byte b;
        while (acc_cnt >= 8) begin
            b.data   = 8'(acc_bits >> (acc_cnt - 8));
            b.last   = 1'b0;
            b.eos    = 1'b0;
            acc_cnt  = acc_cnt - 8;
            acc_bits = acc_bits & low_ones(acc_cnt);
            run      = {run, b};
        end
    endtask

    // Work out the bytes one accepted item causes and queue them.
    task automatic pack_item(logic [1:0] act, logic [9:0] idx, logic [31:0] code,
                             logic [5:0] len, logic [1:0] kind, logic signed [8:0] val);
        t_out_byte run [$];
        t_out_byte b;
        int        l;
        int        v;
        int        sym;
        l   = len;
        v   = val;
        sym = -1;
        case (act)
            ACT_WRITE: begin
                // indexes past the end symbol are dropped; long entries clip
                if (idx < NUM_SYMBOLS) begin
                    if (l > MAX_LEN)
                        l = MAX_LEN;
                    len_tbl[idx]  = l;
                    code_tbl[idx] = 32'({32'd0, code} & low_ones(l));
                end
            end
            ACT_ENCODE: begin
                case (kind)
                    KIND_DIFF: begin
                        if (v < -DIFF_BASE)
                            v = -DIFF_BASE;
                        sym = v + DIFF_BASE;
                    end
                    KIND_ACTUAL: begin
                        if (v < 0)
                            v = 0;
                        sym = v + ACTUAL_BASE;
                    end
                    KIND_NEWLINE: sym = SYM_NEWLINE;
                    default: sym = -1;
                endcase
                if (sym >= 0) begin
                    append_sym(sym);
                    drain_full(run);
                    if (run.size() > 0)
                        run[run.size()-1].last = 1'b1;
                end
            end
            ACT_FINISH: begin
                append_sym(SYM_END);
                drain_full(run);
                if (acc_cnt > 0) begin
                    // fill the tail byte with ones
                    b.data = 8'((acc_bits << (8 - acc_cnt)) | low_ones(8 - acc_cnt));
                    b.last = 1'b0;
                    b.eos  = 1'b0;
                    run    = {run, b};
                end
                acc_bits = '0;
                acc_cnt  = 0;
                if (run.size() > 0) begin
                    run[run.size()-1].last = 1'b1;
                    run[run.size()-1].eos  = 1'b1;
                end
            end
            default: ;
        endcase
        foreach (run[i])
            packed_bytes_q = {packed_bytes_q, run[i]};
    endtask

    // ------------------------------------------------------------------
    // Sender: one item per call, always entered on a rising edge.
    // tvalid stays high on return so back-to-back items need no toggle.
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] act, logic [9:0] idx, logic [31:0] code,
                             logic [5:0] len, logic [1:0] kind, logic [8:0] val);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) < 30)
            gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, val, len, code, idx};
        i_s_axis_tuser  <= {kind, act};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pack_item(act, idx, code, len, kind, val);
    endtask

    task automatic write_entry(int idx, logic [31:0] code, int len);
        send_item(ACT_WRITE, 10'(idx), code, 6'(len), 2'($urandom), 9'($urandom));
    endtask

    task automatic encode_sym(logic [1:0] kind, int val);
        send_item(ACT_ENCODE, 10'($urandom), $urandom, 6'($urandom), kind, 9'(val));
    endtask

    task automatic finish_stream();
        send_item(ACT_FINISH, 10'($urandom), $urandom, 6'($urandom), 2'($urandom),
                  9'($urandom));
    endtask

    // encode a table symbol by mapping it back to kind and value
    task automatic encode_table_sym(int sym);
        if (sym <= 2 * DIFF_BASE)
            encode_sym(KIND_DIFF, sym - DIFF_BASE);
        else if (sym < SYM_NEWLINE)
            encode_sym(KIND_ACTUAL, sym - ACTUAL_BASE);
        else
            encode_sym(KIND_NEWLINE, $urandom_range(0, 511));
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(1, 8);
        if (r < 80) return $urandom_range(9, 32);
        if (r < 92) return 0;
        return $urandom_range(33, 63);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // table after reset: every code is empty, nothing comes out
    task automatic test_empty_table();
        encode_sym(KIND_DIFF, 0);
        finish_stream();
    endtask

    // length clipping, ignored indexes, empty entry, saturating symbols
    task automatic test_entry_limits();
        write_entry(SYM_END, 32'hFFFF_FFFF, 33);
        write_entry(0, 32'h1234_5678, 63);
        write_entry(NUM_SYMBOLS, 32'h0000_00AA, 8);
        write_entry(1023, 32'h0000_001F, 5);
        write_entry(ACTUAL_BASE, 32'hFFFF_FFFF, 0);
        encode_sym(KIND_DIFF, -256);      // clips to the lowest difference
        encode_sym(KIND_DIFF, -255);
        encode_sym(KIND_ACTUAL, -1);      // clips to actual 0, empty code
    endtask

    // the top of each symbol range, newline, and the unused codes
    task automatic test_symbol_mapping();
        write_entry(2 * DIFF_BASE, 32'h0000_0001, 1);
        write_entry(SYM_NEWLINE - 1, 32'h0000_0055, 7);
        write_entry(SYM_NEWLINE, 32'h0000_0005, 3);
        encode_sym(KIND_DIFF, 255);
        encode_sym(KIND_ACTUAL, 255);
        encode_sym(KIND_NEWLINE, 0);
        encode_sym(KIND_UNUSED, 255);
        send_item(ACT_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 6'h3F, KIND_UNUSED, 9'h1FF);
        finish_stream();                  // 32-bit end code plus padding
    endtask

    // finish on a byte boundary, and finish with nothing pending
    task automatic test_finish_aligned();
        write_entry(SYM_END, 32'h0000_003C, 8);
        finish_stream();
        write_entry(SYM_END, 32'h0, 0);
        finish_stream();
    endtask

    task automatic test_random_traffic();
        int r;
        int idx;
        hot_syms[0] = SYM_NEWLINE;
        for (int i = 1; i < 16; i++)
            hot_syms[i] = $urandom_range(0, SYM_NEWLINE - 1);
        foreach (hot_syms[i])
            write_entry(hot_syms[i], $urandom, pick_len());
        write_entry(SYM_END, $urandom, pick_len());
        for (int i = 0; i < 280; i++) begin
            // stretches with and without idling on each side
            if (i % 40 == 0) begin
                tx_idle_en  = ($urandom_range(0, 3) != 0);
                rx_stall_en = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 18) begin
                if ($urandom_range(0, 99) < 15)
                    idx = $urandom_range(0, 1023);
                else if ($urandom_range(0, 9) == 0)
                    idx = SYM_END;
                else
                    idx = hot_syms[$urandom_range(0, 15)];
                write_entry(idx, $urandom, pick_len());
            end else if (r < 88) begin
                encode_table_sym(hot_syms[$urandom_range(0, 15)]);
            end else if (r < 93) begin
                finish_stream();
            end else if (r < 97) begin
                encode_sym(2'($urandom), $urandom_range(0, 511));
            end else begin
                send_item(ACT_UNUSED, 10'($urandom), $urandom, 6'($urandom),
                          2'($urandom), 9'($urandom));
            end
        end
        finish_stream();
    endtask

    // ------------------------------------------------------------------
    // Receiver backpressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        else if (rx_stall_en && $urandom_range(0, 99) < 20)
            rx_hold = pick_gap();
        i_m_axis_tready <= (rx_hold == 0);
    end

    // ------------------------------------------------------------------
    // Output check against the oldest owed byte
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (packed_bytes_q.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0b end %0b", $time,
                         o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]);
                fail_count++;
            end else begin
                head_byte = packed_bytes_q.pop_front();
                if (o_m_axis_tdata !== head_byte.data) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             head_byte.data, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tlast !== head_byte.last) begin
                    $display("%0t: last_of_run expected %0b actual %0b", $time,
                             head_byte.last, o_m_axis_tlast);
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== head_byte.eos) begin
                    $display("%0t: stream_end expected %0b actual %0b", $time,
                             head_byte.eos, o_m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb_prefix_code_stream_encoder: FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
            code_tbl[i] = '0;
            len_tbl[i]  = 0;
        end
        acc_bits = '0;
        acc_cnt  = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_entry_limits();
        test_symbol_mapping();
        test_finish_aligned();
        test_random_traffic();

        i_s_axis_tvalid <= 1'b0;
        rx_stall_en = 1'b0;
        while (packed_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_prefix_code_stream_encoder: PASS");
        else
            $display("tb_prefix_code_stream_encoder: FAIL");
        $finish;
    end

endmodule
